// ===== src/tld_pkg.sv =====
// shared types and constants of the terminal line discipline
package tld_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_KEY     = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_SERVICE = 2'd2;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_ECHO   = 2'd1;
   localparam logic [1:0] KIND_STORE  = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam int unsigned BURST_MAX = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  key_byte;
      logic [15:0] req_count;
      logic [7:0]  proc_id;
      logic [7:0]  caller_id;
      logic [31:0] dest_addr;
   } item_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  char_out;
      logic [31:0] store_addr;
      logic [15:0] count_out;
      logic [7:0]  proc_out;
      logic [7:0]  caller_out;
      logic        last;
   } result_type;

endpackage

// ===== src/tld_ram.sv =====
// generic single-write, single-read ram with registered read data
module tld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tld_ring.sv =====
// key ring: head, tail and fill pointers around the byte store
module tld_ring #(
   parameter int RING_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [1:0] kind,
   input  logic [7:0] key_byte,
   output logic       pop,
   output logic [7:0] pop_data
);
   import tld_pkg::*;

   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;

   assign push = take && (kind == REQ_KEY) && (fill_ff != FILL_W'(RING_DEPTH));
   assign pop  = take && (kind == REQ_SERVICE) && (fill_ff != '0);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         head_in = (head_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
      if (pop) begin
         tail_in = (tail_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   tld_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (head_ff),
      .wr_data (key_byte),
      .rd_en   (pop),
      .rd_addr (tail_ff),
      .rd_data (pop_data)
   );

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RING_DEPTH))
      else $error("ring fill beyond depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      take && kind == REQ_KEY && fill_ff == FILL_W'(RING_DEPTH) |=> $stable(head_ff))
      else $error("key pushed into full ring");

endmodule

// ===== src/tld_edit.sv =====
// line editing stage: pending read state, result burst and output register
module tld_edit (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  tld_pkg::item_type   item,
   input  logic                pop,
   input  logic [7:0]          pop_data,
   output logic                ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output tld_pkg::result_type rsp_item
);
   import tld_pkg::*;

   // stage one: accepted item, ram data arrives alongside
   logic       s1_valid_ff;
   item_type   s1_item_ff;
   logic       s1_pop_ff;

   // pending read
   logic [15:0] left_ff, left_in;
   logic [15:0] done_ff, done_in;
   logic [31:0] paddr_ff, paddr_in;
   logic [7:0]  pproc_ff, pproc_in;
   logic [7:0]  pcaller_ff, pcaller_in;

   // result burst, drained from entry zero
   result_type res_ff [BURST_MAX];
   logic [2:0] rem_ff;

   result_type gen [BURST_MAX];
   logic [2:0] gen_n;
   logic       burst_free;
   logic       s1_go;
   logic [7:0] ch;

   assign ch = pop_data;

   always_comb begin
      for (int i = 0; i < BURST_MAX; i++) begin
         gen[i] = '0;
      end
      gen_n      = '0;
      left_in    = left_ff;
      done_in    = done_ff;
      paddr_in   = paddr_ff;
      pproc_in   = pproc_ff;
      pcaller_in = pcaller_ff;
      case (s1_item_ff.kind)
         REQ_READ: begin
            pcaller_in = s1_item_ff.caller_id;
            pproc_in   = s1_item_ff.proc_id;
            paddr_in   = s1_item_ff.dest_addr;
            left_in    = s1_item_ff.req_count;
            done_in    = '0;
            gen[0].out_kind   = KIND_ACCEPT;
            gen[0].count_out  = s1_item_ff.req_count;
            gen[0].proc_out   = s1_item_ff.proc_id;
            gen[0].caller_out = s1_item_ff.caller_id;
            gen_n = 3'd1;
         end
         REQ_SERVICE: begin
            if (s1_pop_ff && left_ff != '0) begin
               if (ch inside {[CH_SPACE:CH_TILDE]}) begin
                  gen[0].out_kind   = KIND_ECHO;
                  gen[0].char_out   = ch;
                  gen[1].out_kind   = KIND_STORE;
                  gen[1].char_out   = ch;
                  gen[1].store_addr = paddr_ff + 32'(done_ff);
                  gen_n   = 3'd2;
                  done_in = done_ff + 16'd1;
                  left_in = left_ff - 16'd1;
               end else if (ch == CH_BS && done_ff != '0) begin
                  gen[0].out_kind = KIND_ECHO;
                  gen[0].char_out = ch;
                  gen_n   = 3'd1;
                  done_in = done_ff - 16'd1;
                  left_in = left_ff + 16'd1;
               end
               // newline or count reached ends the read
               if (ch == CH_LF || left_in == '0) begin
                  gen[gen_n[1:0]].out_kind         = KIND_ECHO;
                  gen[gen_n[1:0]].char_out         = CH_LF;
                  gen[gen_n[1:0] + 2'd1].out_kind   = KIND_DONE;
                  gen[gen_n[1:0] + 2'd1].count_out  = done_in;
                  gen[gen_n[1:0] + 2'd1].proc_out   = pproc_ff;
                  gen[gen_n[1:0] + 2'd1].caller_out = pcaller_ff;
                  gen_n   = gen_n + 3'd2;
                  left_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < BURST_MAX; i++) begin
         gen[i].last = (3'(i) + 3'd1 == gen_n);
      end
   end

   assign burst_free = (rem_ff == '0) || (rem_ff == 3'd1 && rsp_tready);
   assign s1_go      = s1_valid_ff && (gen_n == '0 || burst_free);
   assign ready      = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rem_ff      <= '0;
         left_ff     <= '0;
         done_ff     <= '0;
         paddr_ff    <= '0;
         pproc_ff    <= '0;
         pcaller_ff  <= '0;
      end else begin
         if (ready) begin
            s1_valid_ff <= take;
         end
         if (s1_go) begin
            left_ff    <= left_in;
            done_ff    <= done_in;
            paddr_ff   <= paddr_in;
            pproc_ff   <= pproc_in;
            pcaller_ff <= pcaller_in;
         end
         if (s1_go && gen_n != '0) begin
            rem_ff <= gen_n;
         end else if (rsp_tvalid && rsp_tready) begin
            rem_ff <= rem_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready && take) begin
         s1_item_ff <= item;
         s1_pop_ff  <= pop;
      end
      if (s1_go && gen_n != '0) begin
         for (int i = 0; i < BURST_MAX; i++) begin
            res_ff[i] <= gen[i];
         end
      end else if (rsp_tvalid && rsp_tready) begin
         for (int i = 0; i < BURST_MAX - 1; i++) begin
            res_ff[i] <= res_ff[i + 1];
         end
      end
   end

   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_item   = res_ff[0];

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd4)
      else $error("burst count out of range");

   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.last |-> rem_ff == 3'd1)
      else $error("last flag before end of burst");

   a_end_has_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rem_ff == 3'd1 |-> rsp_item.last)
      else $error("burst ends without last flag");

   // a burst that closes with a completion leaves no read pending
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_item_ff.kind == REQ_SERVICE && gen_n != '0
         && gen[gen_n[1:0] - 2'd1].out_kind == KIND_DONE |=> left_ff == '0)
      else $error("read still pending after completion");

endmodule

// ===== src/terminal_line_discipline.sv =====
// top level of the terminal line discipline
//
// input channel req_*: one item per key byte, read request or service request,
// the kind on req_tuser. key items fill a ring of RING_DEPTH bytes (dropped
// when full), service items pop one byte and run it through line editing of
// the pending read. result channel rsp_*: accept, echo, store and complete
// items, the kind on rsp_tuser, rsp_tlast on the final result of each input.
// path: an item is held in the input register, with the ram read beside it,
// then its results go to the result register, waiting while a burst drains.
// throughput: one item per cycle while no earlier burst is draining; an item
// that yields results holds the editing stage while its burst drains, the
// ram port giving one pop per cycle. items that yield nothing never wait on
// the result side.
// a stalled receiver holds the current result steady; the editing stage
// keeps one more item, then req_tready drops.
// reset empties the ring and clears any pending read. ring contents are not
// cleared, as only written entries are ever popped.
module terminal_line_discipline #(
   parameter int RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // key_byte[7:0], req_count[23:8], proc_id[31:24], caller_id[39:32],
   // dest_addr[71:40]
   input  logic [71:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // char_out[7:0], store_addr[39:8], count_out[55:40], proc_out[63:56],
   // caller_out[71:64]
   output logic [71:0] rsp_tdata,
   // out_kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import tld_pkg::*;

   item_type   item;
   result_type rsp_item;
   logic       take;
   logic       pop;
   logic [7:0] pop_data;

   // unpack the incoming item
   assign item.kind      = req_tuser;
   assign item.key_byte  = req_tdata[7:0];
   assign item.req_count = req_tdata[23:8];
   assign item.proc_id   = req_tdata[31:24];
   assign item.caller_id = req_tdata[39:32];
   assign item.dest_addr = req_tdata[71:40];

   assign take = req_tvalid && req_tready;

   // ring pointers and byte store
   tld_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .kind     (item.kind),
      .key_byte (item.key_byte),
      .pop      (pop),
      .pop_data (pop_data)
   );

   // line editing and result burst
   tld_edit u_edit (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .item       (item),
      .pop        (pop),
      .pop_data   (pop_data),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // pack the outgoing result
   assign rsp_tdata = {rsp_item.caller_out, rsp_item.proc_out, rsp_item.count_out,
                       rsp_item.store_addr, rsp_item.char_out};
   assign rsp_tuser = rsp_item.out_kind;
   assign rsp_tlast = rsp_item.last;

endmodule

// ===== test/terminal_line_discipline_test.sv =====
// self-checking testbench of the terminal line discipline: key ring, reads, echo and store
module terminal_line_discipline_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tld_pkg::*;

   localparam int RING_DEPTH = 256;
   // request kind that the block ignores
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // cycles allowed for the whole run before it is called hung
   localparam int CYCLE_LIMIT = 400000;
   // cycles to watch for stray results once nothing is outstanding
   localparam int DRAIN_CYCLES = 16;
   // length of the receiver hold-off that backs the block up
   localparam int HOLD_OFF_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // key_byte, req_count, proc_id, caller_id, dest_addr
   logic [71:0] req_tdata;
   // req_type
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // char_out, store_addr, count_out, proc_out, caller_out
   logic [71:0] rsp_tdata;
   // out_kind
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   terminal_line_discipline #(
      .RING_DEPTH(RING_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the terminal state, updated as each item is taken
   logic [7:0]  ring_copy [RING_DEPTH];
   int unsigned ring_head_copy;
   int unsigned ring_tail_copy;
   int unsigned ring_fill_copy;
   logic [15:0] chars_left_copy;
   logic [15:0] chars_done_copy;
   logic [31:0] read_addr_copy;
   logic [7:0]  read_proc_copy;
   logic [7:0]  read_caller_copy;

   // results the block still owes, oldest first
   result_type  line_results_due [$];

   int          mismatches;
   int          cycle_count;
   int          items_sent;
   bit          idle_enable;
   int          hold_left;
   int          stall_left;
   result_type  got_result;
   result_type  want_result;

   // clock, 8 ns period
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hang guard: the run must finish well inside the limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic result_type make_result(logic [1:0] kind, logic [7:0] ch,
                                              logic [31:0] addr, logic [15:0] cnt,
                                              logic [7:0] proc, logic [7:0] caller);
      result_type r;
      r.out_kind   = kind;
      r.char_out   = ch;
      r.store_addr = addr;
      r.count_out  = cnt;
      r.proc_out   = proc;
      r.caller_out = caller;
      r.last       = 1'b0;
      return r;
   endfunction

   // advances the shadow state by one taken item and queues what it must produce
   task automatic apply_line_edit(input item_type it);
      result_type burst [$];
      logic [7:0] ch;
      case (it.kind)
         REQ_KEY: begin
            // a full ring drops the key silently
            if (ring_fill_copy < RING_DEPTH) begin
               ring_copy[ring_head_copy] = it.key_byte;
               ring_head_copy = (ring_head_copy + 1) % RING_DEPTH;
               ring_fill_copy++;
            end
         end
         REQ_READ: begin
            // a new read always replaces the one pending
            read_caller_copy = it.caller_id;
            read_proc_copy   = it.proc_id;
            read_addr_copy   = it.dest_addr;
            chars_left_copy  = it.req_count;
            chars_done_copy  = '0;
            burst.push_back(make_result(KIND_ACCEPT, '0, '0, it.req_count,
                                        it.proc_id, it.caller_id));
         end
         REQ_SERVICE: begin
            if (ring_fill_copy != 0) begin
               ch = ring_copy[ring_tail_copy];
               ring_tail_copy = (ring_tail_copy + 1) % RING_DEPTH;
               ring_fill_copy--;
               // with no read pending the byte is simply thrown away
               if (chars_left_copy != 0) begin
                  if (ch >= CH_SPACE && ch <= CH_TILDE) begin
                     burst.push_back(make_result(KIND_ECHO, ch, '0, '0, '0, '0));
                     burst.push_back(make_result(KIND_STORE, ch,
                                                 read_addr_copy + 32'(chars_done_copy),
                                                 '0, '0, '0));
                     chars_done_copy++;
                     chars_left_copy--;
                  end else if (ch == CH_BS && chars_done_copy != 0) begin
                     burst.push_back(make_result(KIND_ECHO, ch, '0, '0, '0, '0));
                     chars_done_copy--;
                     chars_left_copy++;
                  end
                  if (ch == CH_LF || chars_left_copy == 0) begin
                     burst.push_back(make_result(KIND_ECHO, CH_LF, '0, '0, '0, '0));
                     burst.push_back(make_result(KIND_DONE, '0, '0, chars_done_copy,
                                                 read_proc_copy, read_caller_copy));
                     chars_left_copy = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) line_results_due.push_back(burst[i]);
   endtask

   // offers one item, with an occasional gap first, and waits until it is taken
   task automatic send_item(input item_type it);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {it.dest_addr, it.caller_id, it.proc_id, it.req_count, it.key_byte};
      do @(posedge clock); while (!req_tready);
      apply_line_edit(it);
      if (it.kind != REQ_UNUSED) items_sent++;
   endtask

   task automatic send_key(input logic [7:0] b);
      item_type it;
      it = '0;
      it.kind     = REQ_KEY;
      it.key_byte = b;
      send_item(it);
   endtask

   task automatic send_read(input logic [15:0] cnt, input logic [7:0] proc,
                            input logic [7:0] caller, input logic [31:0] addr);
      item_type it;
      it = '0;
      it.kind      = REQ_READ;
      it.req_count = cnt;
      it.proc_id   = proc;
      it.caller_id = caller;
      it.dest_addr = addr;
      send_item(it);
   endtask

   task automatic send_service();
      item_type it;
      it = '0;
      it.kind = REQ_SERVICE;
      send_item(it);
   endtask

   // pops until the shadow ring says nothing is buffered
   task automatic drain_ring();
      while (ring_fill_copy != 0) send_service();
   endtask

   // one mismatch line, counted
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   // receiver: random stalls, a long hold-off on request, none at the end
   initial begin
      rsp_tready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker: every taken result against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result.out_kind   = rsp_tuser;
         got_result.char_out   = rsp_tdata[7:0];
         got_result.store_addr = rsp_tdata[39:8];
         got_result.count_out  = rsp_tdata[55:40];
         got_result.proc_out   = rsp_tdata[63:56];
         got_result.caller_out = rsp_tdata[71:64];
         got_result.last       = rsp_tlast;
         if (line_results_due.size() == 0) begin
            report_mismatch("result with none owed, kind", 32'(got_result.out_kind), '0);
         end else begin
            want_result = line_results_due.pop_front();
            if (got_result.out_kind != want_result.out_kind)
               report_mismatch("out_kind", 32'(got_result.out_kind),
                               32'(want_result.out_kind));
            if (got_result.char_out != want_result.char_out)
               report_mismatch("char_out", 32'(got_result.char_out),
                               32'(want_result.char_out));
            if (got_result.store_addr != want_result.store_addr)
               report_mismatch("store_addr", got_result.store_addr, want_result.store_addr);
            if (got_result.count_out != want_result.count_out)
               report_mismatch("count_out", 32'(got_result.count_out),
                               32'(want_result.count_out));
            if (got_result.proc_out != want_result.proc_out)
               report_mismatch("proc_out", 32'(got_result.proc_out),
                               32'(want_result.proc_out));
            if (got_result.caller_out != want_result.caller_out)
               report_mismatch("caller_out", 32'(got_result.caller_out),
                               32'(want_result.caller_out));
            if (got_result.last != want_result.last)
               report_mismatch("last", 32'(got_result.last), 32'(want_result.last));
         end
      end
   end

   // empty ring, ignored kind, and a byte popped with no read waiting
   task automatic test_idle_cases();
      item_type it;
      send_service();
      it = '1;
      it.kind = REQ_UNUSED;
      send_item(it);
      send_key(8'h55);
      send_service();
   endtask

   // printable extremes stored across the address wrap, read ends on its count
   task automatic test_read_and_store();
      send_read(16'd3, 8'hFF, 8'h00, 32'hFFFF_FFFE);
      send_key(CH_SPACE);
      send_key(CH_TILDE);
      send_key(8'h41);
      repeat (3) send_service();
   endtask

   // backspace with and without data, control and high bytes, newline, empty read
   task automatic test_line_editing();
      send_read(16'hFFFF, 8'h00, 8'hFF, 32'h0000_0000);
      send_key(CH_BS);
      send_key(8'h78);
      send_key(CH_BS);
      send_key(8'h00);
      send_key(8'h1F);
      send_key(8'h7F);
      send_key(8'hFF);
      send_key(8'h80);
      send_key(CH_LF);
      drain_ring();
      // a zero count is acknowledged but leaves nothing pending
      send_read(16'd0, 8'h5A, 8'hA5, 32'h1234_5678);
      send_key(8'h7A);
      send_service();
   endtask

   // second read overrides the first before any byte arrives
   task automatic test_read_replaced();
      send_read(16'd5, 8'h01, 8'h01, 32'h0000_2000);
      send_read(16'd2, 8'h02, 8'h02, 32'h0000_1000);
      send_key(8'h61);
      send_key(8'h62);
      drain_ring();
   endtask

   // fill the ring past its depth so the extra key is dropped, then pop it all
   task automatic test_ring_full();
      drain_ring();
      send_read(16'd0, 8'h00, 8'h00, 32'h0);
      repeat (RING_DEPTH + 1) send_key(8'($urandom_range(0, 255)));
      send_read(16'hFFFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                32'($urandom));
      drain_ring();
      send_service();
   endtask

   // long receiver hold-off while echo and store bursts keep coming
   task automatic test_backpressure();
      send_read(16'd40, 8'h33, 8'hCC, 32'h8000_0000);
      hold_left = HOLD_OFF_CYCLES;
      repeat (12) begin
         send_key(8'($urandom_range(CH_SPACE, CH_TILDE)));
         send_service();
      end
      send_key(CH_LF);
      send_service();
   endtask

   // byte for a typed line: mostly printable, some editing, some junk
   function automatic logic [7:0] pick_line_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 8'($urandom_range(CH_SPACE, CH_TILDE));
      if (roll < 75) return CH_BS;
      if (roll < 85) return CH_LF;
      return 8'($urandom_range(0, 255));
   endfunction

   // random typed lines against random reads, with some raw noise between them
   task automatic test_random_lines(input int target);
      int start;
      int len;
      logic [15:0] cnt;
      item_type it;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 4) == 0) cnt = 16'($urandom_range(0, 65535));
            else cnt = 16'($urandom_range(1, 8));
            send_read(cnt, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      32'($urandom));
            len = $urandom_range(1, 10);
            repeat (len) begin
               send_key(pick_line_char());
               if ($urandom_range(0, 1) == 0) send_service();
            end
            drain_ring();
            if ($urandom_range(0, 3) == 0) send_service();
         end else begin
            it.kind      = 2'($urandom_range(0, 3));
            it.key_byte  = 8'($urandom_range(0, 255));
            it.req_count = 16'($urandom_range(0, 65535));
            it.proc_id   = 8'($urandom_range(0, 255));
            it.caller_id = 8'($urandom_range(0, 255));
            it.dest_addr = 32'($urandom);
            send_item(it);
         end
      end
   endtask

   // main sequence
   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_KEY;
      reset      <= 1'b1;
      mismatches = 0;
      items_sent = 0;
      hold_left = 0;
      idle_enable = 1'b1;
      ring_head_copy = 0;
      ring_tail_copy = 0;
      ring_fill_copy = 0;
      chars_left_copy = '0;
      chars_done_copy = '0;
      read_addr_copy = '0;
      read_proc_copy = '0;
      read_caller_copy = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_cases();
      test_read_and_store();
      test_line_editing();
      test_read_replaced();
      test_ring_full();
      test_backpressure();
      test_random_lines(130);
      // closing stretch runs at full rate on both sides
      idle_enable = 1'b0;
      test_random_lines(30);

      req_tvalid <= 1'b0;
      while (line_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tld_pkg.sv
src/tld_ram.sv
src/tld_ring.sv
src/tld_edit.sv
src/terminal_line_discipline.sv
test/terminal_line_discipline_test.sv
